// ----- rtl/acst_pkg.sv -----
package acst_pkg;

  localparam int CHANNELS    = 16;
  localparam int SAMPLE_BITS = 16;
  localparam int CH_IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ADDR_W      = CH_IDX_W + 1;
  localparam int ENTRIES     = 2 * CHANNELS;

  localparam int ACTION_W   = 3;
  localparam int CHANNEL_W  = 4;
  localparam int MODE_W     = 8;
  localparam int SAMPLE_W   = 16;
  localparam int RDATA_W    = 16;
  localparam int INTERVAL_W = 16;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 24;

  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd160;

  localparam int MODE_CE_BIT = 7;
  localparam int MODE_PS_BIT = 6;
  localparam int MODE_EF_BIT = 0;

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK        = 3'd0,
    ACT_WRITE_MODE  = 3'd1,
    ACT_READ_MODE   = 3'd2,
    ACT_READ_RESULT = 3'd3,
    ACT_LOAD_LEVEL  = 3'd4
  } action_t;

  typedef struct packed {
    logic                   we;
    logic [ADDR_W-1:0]      waddr;
    logic [SAMPLE_BITS-1:0] wdata;
    logic                   re;
    logic [ADDR_W-1:0]      raddr;
  } mem_req_t;

  typedef struct packed {
    logic              mode_rd;
    logic [MODE_W-1:0] mode_data;
    logic              mem_rd;
    logic              irq;
    logic              running;
  } resp_t;

endpackage

// ----- rtl/acst_sample_ram.sv -----
module acst_sample_ram
  import acst_pkg::*;
(
  input  logic                   clk,
  input  logic                   we,
  input  logic [ADDR_W-1:0]      waddr,
  input  logic [SAMPLE_BITS-1:0] wdata,
  input  logic                   re,
  input  logic [ADDR_W-1:0]      raddr,
  output logic [SAMPLE_BITS-1:0] rdata
);

  logic [SAMPLE_BITS-1:0] mem [ENTRIES];
  logic [SAMPLE_BITS-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/acst_ctrl.sv -----
module acst_ctrl
  import acst_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [INTERVAL_W-1:0] cfg_wr_data,
  input  logic                  accept,
  input  logic [ACTION_W-1:0]   action,
  input  logic [CHANNEL_W-1:0]  channel,
  input  logic [MODE_W-1:0]     mode_value,
  input  logic [SAMPLE_W-1:0]   sample_value,
  output mem_req_t              mem_req,
  output logic                  rd_entry_valid,
  output resp_t                 resp
);

  logic [INTERVAL_W-1:0] interval_r;
  logic [MODE_W-1:0]     mode_r, mode_nxt;
  logic                  run_r, run_nxt;
  logic [INTERVAL_W-1:0] cnt_r, cnt_nxt;
  logic [CHANNELS-1:0]   dirty_r, dirty_nxt;
  logic [CHANNELS-1:0]   bank_r, bank_nxt;
  logic [ENTRIES-1:0]    valid_r, valid_nxt;

  logic                  ch_ok;
  logic [CH_IDX_W-1:0]   ch_idx;
  logic                  rd_bank, wr_bank;
  logic                  irq;

  assign ch_ok   = {1'b0, channel} < (CHANNEL_W + 1)'(CHANNELS);
  assign ch_idx  = CH_IDX_W'(channel);
  // result of a channel sits in the latch bank unless the latch was rewritten since the last scan
  assign rd_bank = dirty_r[ch_idx] ? ~bank_r[ch_idx] : bank_r[ch_idx];
  assign wr_bank = dirty_r[ch_idx] ? bank_r[ch_idx] : ~bank_r[ch_idx];

  always_comb begin
    mode_nxt  = mode_r;
    run_nxt   = run_r;
    cnt_nxt   = cnt_r;
    dirty_nxt = dirty_r;
    bank_nxt  = bank_r;
    valid_nxt = valid_r;
    irq       = 1'b0;
    mem_req   = '0;
    mem_req.waddr = {wr_bank, ch_idx};
    mem_req.raddr = {rd_bank, ch_idx};
    mem_req.wdata = sample_value[SAMPLE_BITS-1:0];
    resp      = '0;
    resp.mode_data = mode_r;
    if (accept) begin
      case (action)
        ACT_TICK: begin
          if (!mode_r[MODE_CE_BIT] || !mode_r[MODE_PS_BIT]) begin
            run_nxt = 1'b0;
          end else begin
            if (!run_r) begin
              run_nxt = 1'b1;
              mode_nxt[MODE_EF_BIT] = 1'b1;
            end
            if (cnt_r < interval_r) begin
              cnt_nxt = cnt_r + 1'b1;
            end else begin
              mode_nxt = mode_r;
              mode_nxt[MODE_EF_BIT] = 1'b0;
              mode_nxt[MODE_CE_BIT] = 1'b0;
              cnt_nxt   = '0;
              dirty_nxt = '0;
              irq       = 1'b1;
            end
          end
        end
        ACT_WRITE_MODE: begin
          mode_nxt = mode_value;
        end
        ACT_READ_MODE: begin
          resp.mode_rd = 1'b1;
        end
        ACT_READ_RESULT: begin
          mem_req.re  = ch_ok;
          resp.mem_rd = ch_ok;
        end
        ACT_LOAD_LEVEL: begin
          if (ch_ok) begin
            mem_req.we                  = 1'b1;
            valid_nxt[{wr_bank, ch_idx}] = 1'b1;
            dirty_nxt[ch_idx]           = 1'b1;
            bank_nxt[ch_idx]            = wr_bank;
          end
        end
        default: begin
        end
      endcase
    end
    resp.irq     = irq;
    resp.running = run_nxt;
  end

  assign rd_entry_valid = valid_r[{rd_bank, ch_idx}];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= INTERVAL_RESET;
      mode_r     <= '0;
      run_r      <= 1'b0;
      cnt_r      <= '0;
      dirty_r    <= '0;
      bank_r     <= '0;
      valid_r    <= '0;
    end else begin
      if (cfg_wr_en) begin
        interval_r <= cfg_wr_data;
      end
      mode_r  <= mode_nxt;
      run_r   <= run_nxt;
      cnt_r   <= cnt_nxt;
      dirty_r <= dirty_nxt;
      bank_r  <= bank_nxt;
      valid_r <= valid_nxt;
    end
  end

endmodule

// ----- rtl/adc_scan_conversion_timer_core.sv -----
// Scan-mode ADC controller core. Every input transfer (tick, mode register write/read,
// result read, analog level load) yields one output transfer; one item is taken per clock
// unless the output stalls; results pass the synchronous sample RAM read, then the output
// register. Latches and results share one 2*CHANNELS-entry RAM with two banks per channel,
// so a scan completion swaps banks through per-channel flags instead of copying. The RAM
// needs no clearing pass: per-entry valid bits give zero for entries never loaded. The user
// must write conv_interval via cfg_wr_en/cfg_wr_data only while idle; nothing enforces it.
module adc_scan_conversion_timer_core
  import acst_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [INTERVAL_W-1:0]  cfg_wr_data,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [2:0] action, [6:3] channel, [14:7] mode_value, [30:15] sample_value, [31] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [15:0] read_data, [16] conversion_irq, [17] running, [23:18] zero
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  logic                   accept;
  mem_req_t               mem_req;
  resp_t                  resp;
  logic                   rd_entry_valid;
  logic [SAMPLE_BITS-1:0] ram_rdata;

  logic                   s1_valid_r;
  resp_t                  s1_resp_r;
  logic                   s1_entry_valid_r;
  logic                   s1_adv;
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic [RDATA_W-1:0]     s1_rdata;

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign accept    = in_tvalid && in_tready;

  acst_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .accept         (accept),
    .action         (in_tdata[2:0]),
    .channel        (in_tdata[6:3]),
    .mode_value     (in_tdata[14:7]),
    .sample_value   (in_tdata[30:15]),
    .mem_req        (mem_req),
    .rd_entry_valid (rd_entry_valid),
    .resp           (resp)
  );

  acst_sample_ram u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    s1_rdata = '0;
    if (s1_resp_r.mode_rd) begin
      s1_rdata = RDATA_W'(s1_resp_r.mode_data);
    end else if (s1_resp_r.mem_rd && s1_entry_valid_r) begin
      s1_rdata = RDATA_W'(ram_rdata);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_resp_r        <= resp;
      s1_entry_valid_r <= rd_entry_valid;
    end
    if (s1_adv) begin
      out_data_r <= {6'd0, s1_resp_r.running, s1_resp_r.irq, s1_rdata};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_irq_running: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_resp_r.irq |-> s1_resp_r.running && !s1_resp_r.mem_rd)
    else $error("scan completion without run state");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r && $stable(s1_resp_r) && $stable(ram_rdata))
    else $error("stalled read stage lost its data");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> !s1_valid_r || s1_adv)
    else $error("read stage overwritten");

endmodule

// ----- dv/adc_scan_checker.sv -----
`timescale 1ns / 1ps

module adc_scan_checker
  import acst_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [INTERVAL_W-1:0]  cfg_wr_data,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  output int                     pending,
  output int                     errors
);

  typedef struct packed {
    logic [RDATA_W-1:0] read_data;
    logic               irq;
    logic               running;
  } scan_resp_t;

  scan_resp_t adc_resp_q[$];

  // shadow of the block's state
  logic [INTERVAL_W-1:0]  interval_q;
  logic                   run_q;
  logic [INTERVAL_W-1:0]  count_q;
  logic [MODE_W-1:0]      mode_q;
  logic [SAMPLE_BITS-1:0] result_q [CHANNELS];
  logic [SAMPLE_BITS-1:0] latch_q  [CHANNELS];

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  always @(posedge clk) begin : mon
    scan_resp_t got;
    scan_resp_t want;
    logic [ACTION_W-1:0]  act;
    logic [CHANNEL_W-1:0] ch;
    logic [MODE_W-1:0]    mv;
    logic [SAMPLE_W-1:0]  sv;
    if (!rst_n) begin
      interval_q = INTERVAL_RESET;
      run_q      = 1'b0;
      count_q    = '0;
      mode_q     = '0;
      for (int i = 0; i < CHANNELS; i++) begin
        result_q[i] = '0;
        latch_q[i]  = '0;
      end
      adc_resp_q.delete();
    end else begin
      if (cfg_wr_en) begin
        interval_q = cfg_wr_data;
      end

      if (out_tvalid && out_tready) begin
        got.read_data = out_tdata[15:0];
        got.irq       = out_tdata[16];
        got.running   = out_tdata[17];
        if (adc_resp_q.size() == 0) begin
          report_mismatch($sformatf("unexpected transfer, tdata %h", out_tdata));
        end else begin
          want = adc_resp_q.pop_front();
          if (got.read_data !== want.read_data)
            report_mismatch($sformatf("read_data %h, expected %h",
                                      got.read_data, want.read_data));
          if (got.irq !== want.irq)
            report_mismatch($sformatf("conversion_irq %b, expected %b",
                                      got.irq, want.irq));
          if (got.running !== want.running)
            report_mismatch($sformatf("running %b, expected %b",
                                      got.running, want.running));
        end
      end

      if (in_tvalid && in_tready) begin
        act  = in_tdata[2:0];
        ch   = in_tdata[6:3];
        mv   = in_tdata[14:7];
        sv   = in_tdata[30:15];
        want = '0;
        case (act)
          ACT_TICK: begin
            if (!mode_q[MODE_CE_BIT] || !mode_q[MODE_PS_BIT]) begin
              run_q = 1'b0;
            end else begin
              if (!run_q) begin
                run_q = 1'b1;
                mode_q[MODE_EF_BIT] = 1'b1;
              end
              if (count_q < interval_q) begin
                count_q = count_q + 1'b1;
              end else begin
                // scan done: latches land in the result registers
                result_q = latch_q;
                mode_q[MODE_EF_BIT] = 1'b0;
                mode_q[MODE_CE_BIT] = 1'b0;
                count_q  = '0;
                want.irq = 1'b1;
              end
            end
          end
          ACT_WRITE_MODE: mode_q = mv;
          ACT_READ_MODE:  want.read_data = RDATA_W'(mode_q);
          ACT_READ_RESULT: begin
            if (int'(ch) < CHANNELS) want.read_data = RDATA_W'(result_q[ch]);
          end
          ACT_LOAD_LEVEL: begin
            if (int'(ch) < CHANNELS)
              latch_q[ch] = SAMPLE_BITS'(sv & SAMPLE_W'((1 << SAMPLE_BITS) - 1));
          end
          default: ;
        endcase
        want.running = run_q;
        adc_resp_q.push_back(want);
      end
    end
    pending = adc_resp_q.size();
  end

endmodule

// ----- dv/tb_adc_scan_conversion_timer_core.sv -----
`timescale 1ns / 1ps

module tb_adc_scan_conversion_timer_core;
  import acst_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS    = 212;

  logic                   clk         = 1'b0;
  logic                   rst_n       = 1'b0;
  logic                   cfg_wr_en   = 1'b0;
  logic [INTERVAL_W-1:0]  cfg_wr_data = '0;
  logic                   in_tvalid   = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata    = '0;
  logic                   out_tvalid;
  logic                   out_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  int   pending;
  int   fail_count;
  int   idle_cycles  = 0;
  logic tx_no_gaps   = 1'b0;
  logic rx_hold_req  = 1'b0;
  logic rx_hold_done = 1'b0;

  always #2 clk = ~clk;

  adc_scan_conversion_timer_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  adc_scan_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .pending    (pending),
    .errors     (fail_count)
  );

  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_item(input action_t act, input logic [CHANNEL_W-1:0] ch,
                           input logic [MODE_W-1:0] mv, input logic [SAMPLE_W-1:0] sv);
    int gap;
    gap = tx_no_gaps ? 0 : pick_idle();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, sv, mv, ch, act};
    do @(posedge clk); while (!in_tready);
  endtask

  // only while idle: drain, let the pipeline settle, then write
  task automatic set_interval(input logic [INTERVAL_W-1:0] v);
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // receiver side
  initial begin : rx_side
    int stall;
    int cyc;
    stall = 0;
    cyc   = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      cyc++;
      if (rx_hold_req && !rx_hold_done) begin
        out_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_hold_done = 1'b1;
      end else if (stall > 0) begin
        out_tready <= 1'b0;
        stall--;
      end else begin
        out_tready <= 1'b1;
        if ((cyc % 1024) >= 160) stall = pick_idle();
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer in %0d cycles, %0d results outstanding",
               WATCHDOG_LIMIT, pending);
      $display("adc_scan_conversion_timer_core test failed");
      $finish;
    end
  end

  initial begin : stim
    logic [INTERVAL_W-1:0] intervals [8];
    int                    r;
    logic [SAMPLE_W-1:0]   sv;
    intervals = '{16'd0, 16'd1, 16'd65535, 16'd3, 16'd9, 16'd160, 16'd25, 16'd2};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, every action, stop/restart, completion, readback
    set_interval(16'd2);
    send_item(ACT_READ_MODE,   4'd0,  8'h00, 16'h0000);
    send_item(ACT_READ_RESULT, 4'd15, 8'h00, 16'h0000);
    send_item(ACT_LOAD_LEVEL,  4'd0,  8'h00, 16'hFFFF);
    send_item(ACT_LOAD_LEVEL,  4'd15, 8'hFF, 16'hABCD);
    send_item(ACT_LOAD_LEVEL,  4'd7,  8'h00, 16'h0000);
    send_item(ACT_TICK,        4'd0,  8'h00, 16'h0000);
    send_item(ACT_WRITE_MODE,  4'd0,  8'hC0, 16'h0000);
    send_item(ACT_TICK,        4'd0,  8'h00, 16'h0000);
    send_item(ACT_READ_MODE,   4'd0,  8'h00, 16'h0000);
    send_item(ACT_WRITE_MODE,  4'd0,  8'h80, 16'h0000);
    send_item(ACT_TICK,        4'd0,  8'h00, 16'h0000);
    send_item(ACT_WRITE_MODE,  4'd0,  8'hFF, 16'h0000);
    send_item(ACT_TICK,        4'd0,  8'h00, 16'h0000);
    send_item(ACT_TICK,        4'd0,  8'h00, 16'h0000);
    send_item(ACT_READ_MODE,   4'd0,  8'h00, 16'h0000);
    send_item(ACT_TICK,        4'd0,  8'h00, 16'h0000);
    send_item(ACT_READ_RESULT, 4'd0,  8'h00, 16'h0000);
    send_item(ACT_READ_RESULT, 4'd15, 8'h00, 16'h0000);
    send_item(ACT_READ_RESULT, 4'd7,  8'h00, 16'h0000);
    send_item(ACT_WRITE_MODE,  4'd0,  8'h40, 16'h0000);
    send_item(ACT_TICK,        4'd0,  8'h00, 16'h0000);
    send_item(ACT_WRITE_MODE,  4'd0,  8'h00, 16'h0000);
    send_item(ACT_READ_MODE,   4'd0,  8'h00, 16'h0000);

    for (int ph = 0; ph < 8; ph++) begin
      set_interval(intervals[ph]);
      tx_no_gaps = (ph == 4) || ($urandom_range(0, 4) == 0);
      if (ph == 1) rx_hold_req = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        r = $urandom_range(0, 99);
        if (r < 8) sv = '0;
        else if (r < 16) sv = '1;
        else sv = SAMPLE_W'($urandom);
        r = $urandom_range(0, 99);
        if (r < 50) begin
          send_item(ACT_TICK, CHANNEL_W'($urandom), MODE_W'($urandom), sv);
        end else if (r < 58) begin
          send_item(ACT_WRITE_MODE, CHANNEL_W'($urandom), {2'b11, 6'($urandom)}, sv);
        end else if (r < 61) begin
          send_item(ACT_WRITE_MODE, CHANNEL_W'($urandom), MODE_W'($urandom), sv);
        end else if (r < 70) begin
          send_item(ACT_READ_MODE, CHANNEL_W'($urandom), MODE_W'($urandom), sv);
        end else if (r < 82) begin
          send_item(ACT_READ_RESULT, CHANNEL_W'($urandom_range(0, 15)),
                    MODE_W'($urandom), sv);
        end else begin
          send_item(ACT_LOAD_LEVEL, CHANNEL_W'($urandom_range(0, 15)),
                    MODE_W'($urandom), sv);
        end
      end
    end

    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("adc_scan_conversion_timer_core test passed");
    end else begin
      $display("adc_scan_conversion_timer_core test failed");
    end
    $finish;
  end

endmodule
